// ===== rtl/pfe_pkg.sv =====
// ----------------------------------------------------------------------------
// pfe_pkg
// shared constants, derived widths and word types for the pulse feature extractor
// ----------------------------------------------------------------------------
package pfe_pkg;

	// record geometry
	localparam int BASELINE_LEN = 10;
	localparam int RECORD_LEN   = 1023;
	localparam int WIN          = (BASELINE_LEN < RECORD_LEN) ? BASELINE_LEN : RECORD_LEN;

	// derived widths
	localparam int WIN_AW = (WIN > 1) ? $clog2(WIN) : 1;
	localparam int RP_W   = $clog2(WIN + 1);
	localparam int IDX_W  = $clog2(RECORD_LEN) + 1;

	// op queue between front and back
	localparam int Q_DEPTH = 16;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	// field widths
	localparam int SAMPLE_W = 16;
	localparam int THR_W    = 16;
	localparam int SUM_W    = 20;
	localparam int INT_W    = 31;
	localparam int GATED_W  = 30;
	localparam int PW_W     = 10;
	localparam int PEAK_W   = 20;
	localparam int CORR_W   = 24;

	localparam logic [THR_W-1:0] THR_RESET = 16'd100;
	localparam logic [PW_W-1:0]  PW_MAX    = '1;

	// one correction job for the back end
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [THR_W-1:0]           thr;
		logic signed [SUM_W-1:0]    wsum;
		logic                       last;
	} op_t;

	// queue status seen by the front end
	typedef struct packed {
		logic [Q_CW-1:0] count;
		logic            full;
	} q_stat_t;

endpackage

// ===== rtl/pfe_queue.sv =====
// ----------------------------------------------------------------------------
// pfe_queue
// short op queue that decouples the front end from the back end
// ----------------------------------------------------------------------------
module pfe_queue import pfe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_en,
	input  op_t     wr_op,
	input  logic    rd_en,
	output op_t     rd_op,
	output logic    q_empty,
	output q_stat_t stat
);

	op_t             mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_CW-1:0] count_q;

	assign rd_op      = mem_q[rd_ptr_q];
	assign q_empty    = (count_q == '0);
	assign stat.count = count_q;
	assign stat.full  = (count_q == Q_CW'(Q_DEPTH));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (!wr_en && rd_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/pfe_front.sv =====
// ----------------------------------------------------------------------------
// pfe_front
// sample intake: record index, baseline window store and sum, window replay
// ----------------------------------------------------------------------------
module pfe_front import pfe_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       cfg_we,
	input  logic [THR_W-1:0]           cfg_wdata,
	input  q_stat_t                    qst,
	output logic                       q_push,
	output op_t                        q_op
);

	localparam logic [IDX_W-1:0] WIN_I  = IDX_W'(WIN);
	localparam logic [IDX_W-1:0] LAST_I = IDX_W'(RECORD_LEN - 1);
	localparam logic [RP_W-1:0]  WIN_R  = RP_W'(WIN);
	localparam logic [RP_W-1:0]  WLST_R = RP_W'(WIN - 1);

	logic signed [SAMPLE_W-1:0] win_mem [WIN];
	logic signed [SAMPLE_W-1:0] rd_q;

	logic [IDX_W-1:0]        idx_q;
	logic signed [SUM_W-1:0] wsum_q;
	logic [THR_W-1:0]        thr_q;
	logic [THR_W-1:0]        thr_snap_q;
	logic                    replay_q;
	logic                    rec_last_q;
	logic [RP_W-1:0]         rptr_q;
	logic                    rd_vld_q;
	logic                    rd_last_q;

	logic                    accept;
	logic                    in_win;
	logic                    win_end;
	logic                    rec_end;
	logic                    issue;
	logic                    replay_end;
	logic signed [SUM_W:0]   sum_ext;
	logic signed [SUM_W-1:0] sum_sat;

	assign full    = replay_q || qst.full;
	assign accept  = push && !full;
	assign in_win  = (idx_q < WIN_I);
	assign win_end = (idx_q == WIN_I - 1'b1);
	assign rec_end = (idx_q == LAST_I);

	// saturating window sum
	always_comb begin
		sum_ext = {wsum_q[SUM_W-1], wsum_q} + (SUM_W+1)'(sample);
		if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
			sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_sat = sum_ext[SUM_W-1:0];
		end
	end

	// replay reads only when the queue can still take the word in the next cycle
	assign issue = replay_q && (rptr_q < WIN_R)
		&& (({1'b0, qst.count} + (Q_CW+1)'(rd_vld_q)) < (Q_CW+1)'(Q_DEPTH));
	assign replay_end = replay_q && (rptr_q == WIN_R) && !rd_vld_q;

	assign q_push = (accept && !in_win) || rd_vld_q;

	always_comb begin
		if (rd_vld_q) begin
			q_op.sample = rd_q;
			q_op.thr    = thr_snap_q;
			q_op.wsum   = wsum_q;
			q_op.last   = rd_last_q;
		end else begin
			q_op.sample = sample;
			q_op.thr    = thr_q;
			q_op.wsum   = wsum_q;
			q_op.last   = rec_end;
		end
	end

	// window memory, registered read
	always_ff @(posedge clk) begin
		if (accept && in_win) begin
			win_mem[idx_q[WIN_AW-1:0]] <= sample;
		end
		rd_q <= win_mem[rptr_q[WIN_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (accept && win_end) begin
			thr_snap_q <= thr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			wsum_q     <= '0;
			thr_q      <= THR_RESET;
			replay_q   <= 1'b0;
			rec_last_q <= 1'b0;
			rptr_q     <= '0;
			rd_vld_q   <= 1'b0;
			rd_last_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			rd_vld_q  <= issue;
			rd_last_q <= issue && (rptr_q == WLST_R) && rec_last_q;
			if (issue) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (accept) begin
				idx_q <= rec_end ? '0 : idx_q + 1'b1;
				if (in_win) begin
					wsum_q <= sum_sat;
				end else if (rec_end) begin
					wsum_q <= '0;
				end
				if (win_end) begin
					replay_q   <= 1'b1;
					rec_last_q <= rec_end;
					rptr_q     <= '0;
				end
			end
			if (replay_end) begin
				replay_q <= 1'b0;
				if (rec_last_q) begin
					wsum_q <= '0;
				end
			end
		end
	end

endmodule

// ===== rtl/pfe_back.sv =====
// ----------------------------------------------------------------------------
// pfe_back
// baseline correction, gating and record accumulators with result register
// ----------------------------------------------------------------------------
module pfe_back import pfe_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  op_t                       head,
	input  logic                      q_empty,
	output logic                      q_pop,
	output logic                      empty,
	input  logic                      pop,
	output logic signed [SUM_W-1:0]   baseline_sum,
	output logic signed [INT_W-1:0]   total_integral,
	output logic [GATED_W-1:0]        gated_integral,
	output logic [PW_W-1:0]           pulse_width,
	output logic [PEAK_W-1:0]         peak_height
);

	localparam logic signed [CORR_W-1:0] WIN_S = CORR_W'(WIN);

	// stage 1: corrected value and gate decision
	logic signed [CORR_W-1:0] prod;
	logic signed [CORR_W-1:0] corr_c;
	logic [CORR_W-1:0]        thr_sc;
	logic                     gate_c;

	logic                     valid_s1;
	logic signed [CORR_W-1:0] corr_s1;
	logic                     gate_s1;
	logic                     last_s1;
	logic signed [SUM_W-1:0]  wsum_s1;

	// accumulators
	logic signed [INT_W-1:0]  int_q;
	logic [GATED_W-1:0]       gated_q;
	logic [PW_W-1:0]          width_q;
	logic [PEAK_W-1:0]        peak_q;
	logic                     out_valid_q;

	logic signed [INT_W:0]    int_sum;
	logic [GATED_W:0]         g_sum;
	logic signed [INT_W-1:0]  int_n;
	logic [GATED_W-1:0]       gated_n;
	logic [PW_W-1:0]          width_n;
	logic [PEAK_W-1:0]        peak_n;
	logic                     adv;
	logic                     fold;

	assign prod   = $signed(CORR_W'(head.sample)) * WIN_S;
	assign corr_c = CORR_W'(head.wsum) - prod;
	assign thr_sc = CORR_W'(head.thr) * CORR_W'(WIN);
	assign gate_c = corr_c > $signed(thr_sc);

	// hold stage 1 when a finished record cannot enter the result register
	assign adv   = !(valid_s1 && last_s1 && out_valid_q && !pop);
	assign q_pop = adv && !q_empty;
	assign fold  = valid_s1 && adv;
	assign empty = !out_valid_q;

	always_comb begin
		int_sum = {int_q[INT_W-1], int_q} + (INT_W+1)'(corr_s1);
		if (int_sum[INT_W] != int_sum[INT_W-1]) begin
			int_n = int_sum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
		end else begin
			int_n = int_sum[INT_W-1:0];
		end

		g_sum   = {1'b0, gated_q} + (GATED_W+1)'(corr_s1[CORR_W-2:0]);
		gated_n = gated_q;
		width_n = width_q;
		if (gate_s1) begin
			gated_n = g_sum[GATED_W] ? '1 : g_sum[GATED_W-1:0];
			if (width_q != PW_MAX) begin
				width_n = width_q + 1'b1;
			end
		end

		peak_n = peak_q;
		if (corr_s1 > $signed(CORR_W'(peak_q))) begin
			peak_n = (corr_s1[CORR_W-1:PEAK_W] != '0) ? '1 : corr_s1[PEAK_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			corr_s1 <= corr_c;
			gate_s1 <= gate_c;
			last_s1 <= head.last;
			wsum_s1 <= head.wsum;
		end
		if (fold && last_s1) begin
			baseline_sum   <= wsum_s1;
			total_integral <= int_n;
			gated_integral <= gated_n;
			pulse_width    <= width_n;
			peak_height    <= peak_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			int_q       <= '0;
			gated_q     <= '0;
			width_q     <= '0;
			peak_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				valid_s1 <= !q_empty;
			end
			if (fold) begin
				if (last_s1) begin
					int_q   <= '0;
					gated_q <= '0;
					width_q <= '0;
					peak_q  <= '0;
				end else begin
					int_q   <= int_n;
					gated_q <= gated_n;
					width_q <= width_n;
					peak_q  <= peak_n;
				end
			end
			if (fold && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/pulse_feature_extractor_top.sv =====
// ----------------------------------------------------------------------------
// pulse_feature_extractor_top
// baseline subtraction and charge integration over fixed-length waveform records
// ----------------------------------------------------------------------------
//
// channel   ports                                    handshake
// -------   ---------------------------------------  -------------------------
// samples   sample[15:0] signed                      push / full
// results   baseline_sum, total_integral,            empty / pop
//           gated_integral, pulse_width, peak_height
// config    cfg_wdata[15:0] (gate_threshold)         cfg_we, no wait
//
// a sample word is taken every cycle while the op queue has room, except right after
// the sample that closes the baseline window: then full stays high while the stored
// window is read out of its memory one word per cycle into the op queue, as room allows
// the back end folds one op per cycle while the queue holds ops and no finished
// record waits on an occupied result register; a record's result enters that register
// when its last op folds out of stage 1; a waiting result only stalls the back end;
// the front keeps taking samples until the op queue fills
// arst_n clears the record state; the threshold resets to 100
//
module pulse_feature_extractor_top import pfe_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	// sample input
	input  logic                        push,
	output logic                        full,
	input  logic signed [SAMPLE_W-1:0]  sample,
	// threshold register
	input  logic                        cfg_we,
	input  logic [THR_W-1:0]            cfg_wdata,
	// result output
	output logic                        empty,
	input  logic                        pop,
	output logic signed [SUM_W-1:0]     baseline_sum,
	output logic signed [INT_W-1:0]     total_integral,
	output logic [GATED_W-1:0]          gated_integral,
	output logic [PW_W-1:0]             pulse_width,
	output logic [PEAK_W-1:0]           peak_height
);

	// front to queue
	logic    q_wr;
	op_t     q_wr_op;
	q_stat_t q_stat;

	// queue to back
	op_t     q_head;
	logic    q_empty;
	logic    q_rd;

	// intake, window store, baseline sum and window replay
	pfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.qst       (q_stat),
		.q_push    (q_wr),
		.q_op      (q_wr_op)
	);

	// op words carry sample, threshold and baseline sum so the back is self-contained
	pfe_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_op   (q_wr_op),
		.rd_en   (q_rd),
		.rd_op   (q_head),
		.q_empty (q_empty),
		.stat    (q_stat)
	);

	// correction, gating, accumulation and the result register
	pfe_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (q_head),
		.q_empty        (q_empty),
		.q_pop          (q_rd),
		.empty          (empty),
		.pop            (pop),
		.baseline_sum   (baseline_sum),
		.total_integral (total_integral),
		.gated_integral (gated_integral),
		.pulse_width    (pulse_width),
		.peak_height    (peak_height)
	);

endmodule

// ===== rtl/pfe_checker.sv =====
// ----------------------------------------------------------------------------
// pfe_checker
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
module pfe_checker import pfe_pkg::*; (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        push,
	input logic                        full,
	input logic signed [SAMPLE_W-1:0]  sample,
	input logic                        cfg_we,
	input logic [THR_W-1:0]            cfg_wdata,
	input logic                        empty,
	input logic                        pop,
	input logic signed [SUM_W-1:0]     baseline_sum,
	input logic signed [INT_W-1:0]     total_integral,
	input logic [GATED_W-1:0]          gated_integral,
	input logic [PW_W-1:0]             pulse_width,
	input logic [PEAK_W-1:0]           peak_height
);

	// a waiting result word holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(gated_integral) && $stable(peak_height)
			&& $stable(pulse_width) && $stable(total_integral) && $stable(baseline_sum)))
		else $error("result word changed while stalled");

	// no gated samples means no gated charge
	a_gate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pulse_width == '0) |-> (gated_integral == '0))
		else $error("gated integral without gated samples");

	// any gated charge implies a positive peak
	a_gate_peak: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && gated_integral != '0) |-> (peak_height != '0 && pulse_width != '0))
		else $error("gated charge without peak or width");

endmodule

bind pulse_feature_extractor_top pfe_checker u_pfe_checker (.*);

// ===== dv/pulse_feature_extractor_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_feature_extractor_top_tb
// self-checking bench for the pulse feature extractor: records of shaped pulses,
// noise and rail values are streamed in, every record result is compared with a
// cycle-free feature predictor or a hand-computed row, and the gate threshold is
// retuned between and inside records while both sides idle, stall and back-pressure at random
// ----------------------------------------------------------------------------
module pulse_feature_extractor_top_tb;
	import pfe_pkg::*;

	// run shape
	localparam int NUM_RAND_RECORDS = 32;
	localparam int SETTLE           = Q_DEPTH + WIN + 16;   // drain time of the op pipe
	localparam int HOLD_CYCLES      = 400;                  // long receiver hold-off
	localparam int WATCHDOG_LIMIT   = 4000;
	localparam int MAX_REPORTS      = 10;

	// saturation limits of the accumulators
	localparam longint SUM_HI   = (longint'(1) << (SUM_W - 1)) - 1;
	localparam longint SUM_LO   = -(longint'(1) << (SUM_W - 1));
	localparam longint INTEG_HI = (longint'(1) << (INT_W - 1)) - 1;
	localparam longint INTEG_LO = -(longint'(1) << (INT_W - 1));
	localparam longint GATED_HI = (longint'(1) << GATED_W) - 1;
	localparam longint PEAK_HI  = (longint'(1) << PEAK_W) - 1;
	localparam longint SMP_HI   = (longint'(1) << (SAMPLE_W - 1)) - 1;
	localparam longint SMP_LO   = -(longint'(1) << (SAMPLE_W - 1));
	localparam logic [THR_W-1:0] THR_TOP = '1;

	// idle phases: sender idle percent, receiver stall percent
	localparam int SEND_IDLE [4] = '{0, 61, 0, 22};
	localparam int RECV_IDLE [4] = '{0, 0, 61, 22};

	// shapes of random records
	typedef enum int {REC_PULSE, REC_NOISE, REC_RAIL} rec_kind_e;

	// one record result
	typedef struct {
		logic signed [SUM_W-1:0] bsum;
		logic signed [INT_W-1:0] tint;
		logic [GATED_W-1:0]      gint;
		logic [PW_W-1:0]         pw;
		logic [PEAK_W-1:0]       pk;
	} feat_t;

	// hand-computed result tied to a record number
	typedef struct {
		int    rec;
		feat_t res;
	} pinned_t;

	// directed record: window value, body value, one rectangular pulse,
	// threshold before the record (-1 keeps it) and an optional retune inside it
	typedef struct {
		int thr;
		int mid_at;
		int mid_thr;
		int base;
		int body;
		int pls_at;
		int pls_len;
		int pls_val;
		bit pinned;
		int e_bsum;
		int e_tint;
		int e_gint;
		int e_pw;
		int e_pk;
	} rec_row_t;

	rec_row_t dir_rows [9] = '{
		// reset threshold, flat zero record
		'{-1, -1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0},
		// most negative window, most positive body, threshold zero
		'{0, -1, 0, -32768, 32767, 0, 0, 0, 1, -327680, -663869550, 0, 0, 0},
		// most positive window, most negative body, top threshold just misses
		'{65535, -1, 0, 32767, -32768, 0, 0, 0, 1, 327670, 663869550, 0, 0, 655350},
		// same record with threshold zero, every body sample gated
		'{0, -1, 0, 32767, -32768, 0, 0, 0, 1, 327670, 663869550, 663869550, 1013, 655350},
		// threshold one step below the body amplitude
		'{65534, -1, 0, 32767, -32768, 0, 0, 0, 0, 0, 0, 0, 0, 0},
		// pulse inside the baseline window, seen only at window replay
		'{100, -1, 0, 0, 0, 3, 5, -2000, 0, 0, 0, 0, 0, 0},
		// retune right before the sample that closes the window
		'{50, 9, 2000, 200, 200, 300, 40, -1500, 0, 0, 0, 0, 0, 0},
		// retune mid record, pulse runs into the last sample
		'{1, 500, 0, -5, -5, 1000, 23, -30000, 0, 0, 0, 0, 0, 0},
		// retune right after the replay, single-sample spike from the top rail
		'{100, 10, 7, 32767, 32767, 600, 1, -32768, 0, 0, 0, 0, 0, 0}
	};

	// dut ports
	logic                       clk;
	logic                       arst_n;
	logic                       push;
	logic                       full;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       cfg_we;
	logic [THR_W-1:0]           cfg_wdata;
	logic                       empty;
	logic                       pop;
	logic signed [SUM_W-1:0]    baseline_sum;
	logic signed [INT_W-1:0]    total_integral;
	logic [GATED_W-1:0]         gated_integral;
	logic [PW_W-1:0]            pulse_width;
	logic [PEAK_W-1:0]          peak_height;

	// feature predictor state
	logic signed [SAMPLE_W-1:0] win_mem [WIN];
	int                         sidx = 0;
	longint                     wsum = 0;
	longint                     integ = 0;
	longint                     gacc = 0;
	longint                     pk = 0;
	int                         wcnt = 0;
	logic [THR_W-1:0]           thr_now = THR_RESET;

	// expected features and bookkeeping
	feat_t   feat_q [$];
	pinned_t pin_q [$];
	logic signed [SAMPLE_W-1:0] rec_buf [RECORD_LEN];
	int      rec_sent = 0;
	int      recs_closed = 0;
	int      send_idle = 0;
	int      recv_idle = 0;
	bit      hold_armed = 1'b0;
	int      fails = 0;
	int      n_words = 0;
	int      n_results = 0;
	int      n_retunes = 0;
	int      n_holds = 0;
	int      n_full_stalls = 0;
	int      quiet_cycles = 0;

	pulse_feature_extractor_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.sample         (sample),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.empty          (empty),
		.pop            (pop),
		.baseline_sum   (baseline_sum),
		.total_integral (total_integral),
		.gated_integral (gated_integral),
		.pulse_width    (pulse_width),
		.peak_height    (peak_height)
	);

	// 4 ns clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic longint sat(input longint v, input longint lo, input longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] clip_sample(input longint v);
		return SAMPLE_W'(sat(v, SMP_LO, SMP_HI));
	endfunction

	// one baseline-corrected sample into the record accumulators
	task automatic fold_corrected(input logic signed [SAMPLE_W-1:0] raw);
		longint corr;
		corr = wsum - longint'(WIN) * raw;
		integ = sat(integ + corr, INTEG_LO, INTEG_HI);
		if (corr > longint'(thr_now) * WIN) begin
			gacc = sat(gacc + corr, 0, GATED_HI);
			if (wcnt < PW_MAX)
				wcnt++;
		end
		if (corr > pk)
			pk = sat(corr, 0, PEAK_HI);
	endtask

	// advance the predictor by one accepted sample word
	task automatic integrate_word(input logic signed [SAMPLE_W-1:0] s, output bit closed,
			output feat_t res);
		closed = 1'b0;
		res = '{default: '0};
		if (sidx < WIN) begin
			win_mem[sidx] = s;
			wsum = sat(wsum + s, SUM_LO, SUM_HI);
			// window just completed: replay the stored samples in order
			if (sidx == WIN - 1)
				for (int i = 0; i < WIN; i++)
					fold_corrected(win_mem[i]);
		end else begin
			fold_corrected(s);
		end
		if (sidx >= RECORD_LEN - 1) begin
			closed = 1'b1;
			res.bsum = SUM_W'(wsum);
			res.tint = INT_W'(integ);
			res.gint = GATED_W'(gacc);
			res.pw = PW_W'(wcnt);
			res.pk = PEAK_W'(pk);
			sidx = 0;
			wsum = 0;
			integ = 0;
			gacc = 0;
			wcnt = 0;
			pk = 0;
		end else begin
			sidx++;
		end
	endtask

	function automatic void flag_mismatch(input string what, input feat_t want, input feat_t got);
		fails++;
		if (fails <= MAX_REPORTS)
			$display("%0t mismatch (%s): exp bsum %0d tint %0d gint %0d pw %0d pk %0d | got bsum %0d tint %0d gint %0d pw %0d pk %0d",
				$time, what, want.bsum, want.tint, want.gint, want.pw, want.pk,
				got.bsum, got.tint, got.gint, got.pw, got.pk);
	endfunction

	function automatic logic [THR_W-1:0] pick_threshold();
		case ($urandom_range(3))
			0: return '0;
			1: return THR_TOP;
			2: return THR_W'($urandom_range(3000));
			default: return THR_W'($urandom);
		endcase
	endfunction

	// monitor: predicts on every accepted sample word, checks every accepted result word,
	// and runs the watchdog on cycles where neither side moves a word
	always @(posedge clk) begin
		feat_t got;
		feat_t want;
		bit    closed;
		if (arst_n) begin
			if (cfg_we)
				thr_now = cfg_wdata;
			if (push && full)
				n_full_stalls++;
			if (push && !full) begin
				n_words++;
				integrate_word(sample, closed, want);
				if (closed) begin
					// hand-computed rows replace the predicted value
					if (pin_q.size() != 0 && pin_q[0].rec == recs_closed)
						feat_q.push_back(pin_q.pop_front().res);
					else
						feat_q.push_back(want);
					recs_closed++;
				end
			end
			if (pop && !empty) begin
				got.bsum = baseline_sum;
				got.tint = total_integral;
				got.gint = gated_integral;
				got.pw = pulse_width;
				got.pk = peak_height;
				n_results++;
				if (feat_q.size() == 0) begin
					flag_mismatch("result word with nothing expected", got, got);
				end else begin
					want = feat_q.pop_front();
					if (got.bsum !== want.bsum || got.tint !== want.tint ||
							got.gint !== want.gint || got.pw !== want.pw ||
							got.pk !== want.pk)
						flag_mismatch("feature fields", want, got);
				end
			end
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t watchdog: no word moved for %0d cycles, %0d results outstanding",
					$time, quiet_cycles, feat_q.size());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// receiver: random pop, with one long counted hold-off whenever armed
	initial begin
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_armed && !empty) begin
				hold_armed = 1'b0;
				n_holds++;
				pop <= 1'b0;
				for (int k = 0; k < HOLD_CYCLES; k++)
					@(posedge clk);
			end else begin
				pop <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// offer one sample word, idling first at the current sender rate
	task automatic send_word(input logic signed [SAMPLE_W-1:0] s);
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	// threshold write: sender pauses until every result is in and the op pipe is quiet
	task automatic retune(input logic [THR_W-1:0] value);
		push <= 1'b0;
		while (feat_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		n_retunes++;
	endtask

	// stream rec_buf as one record; idle phase changes every two records
	task automatic send_record(input int mid_at, input logic [THR_W-1:0] mid_thr);
		send_idle = SEND_IDLE[(rec_sent / 2) % 4];
		recv_idle = RECV_IDLE[(rec_sent / 2) % 4];
		for (int i = 0; i < RECORD_LEN; i++) begin
			if (i == mid_at)
				retune(mid_thr);
			send_word(rec_buf[i]);
		end
		rec_sent++;
	endtask

	initial begin
		rec_kind_e kind;
		pinned_t   pin;
		bit        calm_next;
		int        mid;
		int        lvl;
		int        spread;
		int        npulse;
		int        at;
		int        len;
		int        amp;
		arst_n = 1'b0;
		push = 1'b0;
		sample = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		calm_next = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed records: rails, threshold extremes, window replay, retunes
		foreach (dir_rows[n]) begin
			if (dir_rows[n].thr >= 0)
				retune(THR_W'(dir_rows[n].thr));
			for (int i = 0; i < RECORD_LEN; i++) begin
				if (i >= dir_rows[n].pls_at && i < dir_rows[n].pls_at + dir_rows[n].pls_len)
					rec_buf[i] = SAMPLE_W'(dir_rows[n].pls_val);
				else if (i < WIN)
					rec_buf[i] = SAMPLE_W'(dir_rows[n].base);
				else
					rec_buf[i] = SAMPLE_W'(dir_rows[n].body);
			end
			if (dir_rows[n].pinned) begin
				pin.rec = rec_sent;
				pin.res.bsum = SUM_W'(dir_rows[n].e_bsum);
				pin.res.tint = INT_W'(dir_rows[n].e_tint);
				pin.res.gint = GATED_W'(dir_rows[n].e_gint);
				pin.res.pw = PW_W'(dir_rows[n].e_pw);
				pin.res.pk = PEAK_W'(dir_rows[n].e_pk);
				pin_q.push_back(pin);
			end
			send_record(dir_rows[n].mid_at, THR_W'(dir_rows[n].mid_thr));
		end

		// random records: mostly pulses on a noisy baseline, some raw noise and rail mixes
		for (int r = 0; r < NUM_RAND_RECORDS; r++) begin
			case ($urandom_range(9))
				6, 7: kind = REC_NOISE;
				8, 9: kind = REC_RAIL;
				default: kind = REC_PULSE;
			endcase
			case (kind)
				REC_NOISE: begin
					for (int i = 0; i < RECORD_LEN; i++)
						rec_buf[i] = SAMPLE_W'($urandom);
				end
				REC_RAIL: begin
					for (int i = 0; i < RECORD_LEN; i++)
						case ($urandom_range(4))
							0: rec_buf[i] = SAMPLE_W'(SMP_LO);
							1: rec_buf[i] = SAMPLE_W'(SMP_HI);
							2: rec_buf[i] = '0;
							3: rec_buf[i] = '1;
							default: rec_buf[i] = SAMPLE_W'($urandom);
						endcase
				end
				default: begin
					lvl = int'($urandom_range(4000)) - 2000;
					spread = int'($urandom_range(64));
					for (int i = 0; i < RECORD_LEN; i++)
						rec_buf[i] = clip_sample(lvl + int'($urandom_range(2 * spread)) - spread);
					npulse = int'($urandom_range(3));
					for (int p = 0; p < npulse; p++) begin
						// now and then the first pulse lands inside the baseline window
						if (p == 0 && $urandom_range(3) == 0)
							at = int'($urandom_range(WIN - 1));
						else
							at = int'($urandom_range(RECORD_LEN - 1));
						len = int'($urandom_range(120, 1));
						amp = int'($urandom_range(30000, 1));
						if ($urandom_range(4) == 0)
							amp = -amp;   // overshoot above baseline
						for (int k = 0; k < len && at + k < RECORD_LEN; k++)
							rec_buf[at + k] = clip_sample(lvl - longint'(amp) * (len - k) / len);
					end
				end
			endcase
			if (!calm_next && $urandom_range(1) == 1)
				retune(pick_threshold());
			mid = -1;
			if (!calm_next && $urandom_range(3) == 0)
				mid = int'($urandom_range(RECORD_LEN - 1, 1));
			calm_next = 1'b0;
			// long hold-off at this record's result while the next record keeps coming
			if (r % 10 == 4) begin
				hold_armed = 1'b1;
				calm_next = 1'b1;
			end
			send_record(mid, pick_threshold());
		end

		// wait for the last results, then let the pipe go quiet
		push <= 1'b0;
		while (feat_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("ran %0d records (%0d sample words), checked %0d result words, %0d threshold writes",
			rec_sent, n_words, n_results, n_retunes);
		$display("receiver hold-offs %0d, input cycles blocked by full %0d, failures %0d",
			n_holds, n_full_stalls, fails);
		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
